### hdl/chip8_instruction_core_defines.svh
// assertion macros shared by the core's modules
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

`ifndef SYNTH
`define C8_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c8 check failed");
`define C8_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c8 check failed");
`else
`define C8_ASSERT_NOW(lbl, ante, cons)
`define C8_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hdl/c8_pkg.sv
package c8_pkg;

    localparam int MEM_SIZE      = 4096;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_W      = 64;
    localparam int SCREEN_H      = 32;
    localparam int PROGRAM_START = 512;

    localparam int AW  = $clog2(MEM_SIZE);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int RW  = $clog2(SCREEN_H);
    localparam int XW  = $clog2(SCREEN_W);
    localparam int FONT_BYTES = 80;

    // item commands
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_STEP  = 3'd1;
    localparam logic [2:0] CMD_KEY   = 3'd2;
    localparam logic [2:0] CMD_ROW   = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_OVER    = 2'd2;
    localparam logic [1:0] ST_UNDER   = 2'd3;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SE   = 4'h3;
    localparam logic [3:0] OPG_SNE  = 4'h4;
    localparam logic [3:0] OPG_SEV  = 4'h5;
    localparam logic [3:0] OPG_LD   = 4'h6;
    localparam logic [3:0] OPG_ADD  = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNEV = 4'h9;
    localparam logic [3:0] OPG_LDI  = 4'hA;
    localparam logic [3:0] OPG_JPV  = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_SKP  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    // alu sub-codes
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // low-byte codes
    localparam logic [7:0] LO_SKP  = 8'h9E;
    localparam logic [7:0] LO_SKNP = 8'hA1;
    localparam logic [7:0] LO_GDT  = 8'h07;
    localparam logic [7:0] LO_WKEY = 8'h0A;
    localparam logic [7:0] LO_SDT  = 8'h15;
    localparam logic [7:0] LO_SST  = 8'h18;
    localparam logic [7:0] LO_ADDI = 8'h1E;
    localparam logic [7:0] LO_FONT = 8'h29;
    localparam logic [7:0] LO_BCD  = 8'h33;
    localparam logic [7:0] LO_STO  = 8'h55;
    localparam logic [7:0] LO_LDM  = 8'h65;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_MEMWR,
        OP_MEMRD,
        OP_KEY,
        OP_FETCH0,
        OP_FETCH1,
        OP_FETCH2,
        OP_READ_VX,
        OP_READ_VY,
        OP_EXEC,
        OP_DRAW_RD,
        OP_DRAW_WR,
        OP_DRAW_FLAG,
        OP_BCD_WR,
        OP_STORE_WR,
        OP_LOAD_RD,
        OP_LOAD_WR,
        OP_RETIRE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        waiting;
        logic [15:0] opc;
        logic [4:0]  cnt;
        logic        clear_last;
    } dp_stat_t;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25,
            7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44,
            7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72,
            7'd74, 7'd75, 7'd77:                  b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51,
            7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37:             b = 8'h20;
            7'd6:                                 b = 8'h60;
            7'd9:                                 b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
            7'd78, 7'd79:                         b = 8'h80;
            7'd38, 7'd39:                         b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69:   b = 8'hE0;
            default:                              b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/c8_req_if.sv
interface c8_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys_down;
    logic [3:0]  key_value;
    logic [4:0]  row;

    modport source (output valid, command, address, data, keys_down, key_value, row,
                    input ready);
    modport sink   (input valid, command, address, data, keys_down, key_value, row,
                    output ready);
endinterface

### hdl/c8_rsp_if.sv
interface c8_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [63:0] display_row;
    logic [11:0] pc;
    logic        waiting;
    logic        sound_on;
    logic [1:0]  status;

    modport source (output valid, read_data, display_row, pc, waiting, sound_on, status,
                    input ready);
    modport sink   (input valid, read_data, display_row, pc, waiting, sound_on, status,
                    output ready);
endinterface

### hdl/c8_ram.sv
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/c8_datapath.sv
`include "chip8_instruction_core_defines.svh"

module c8_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  c8_pkg::dp_cmd_t    cmd,
    output c8_pkg::dp_stat_t   stat,
    input  logic [2:0]         command,
    input  logic [11:0]        address,
    input  logic [7:0]         data,
    input  logic [15:0]        keys_down,
    input  logic [3:0]         key_value,
    input  logic [4:0]         row,
    output logic [7:0]         read_data,
    output logic [63:0]        display_row,
    output logic [11:0]        pc,
    output logic               waiting,
    output logic               sound_on,
    output logic [1:0]         status
);

    // latched beat
    logic [2:0]  cmd_b_reg;
    logic [11:0] addr_b_reg;
    logic [7:0]  data_b_reg;
    logic [15:0] keys_b_reg;
    logic [3:0]  keyv_b_reg;
    logic [4:0]  row_b_reg;

    // machine state
    logic [7:0]               v_reg [16];
    logic [11:0]              i_reg;
    logic [11:0]              pc_reg;
    logic [11:0]              stk_reg [c8_pkg::STACK_DEPTH];
    logic [c8_pkg::SPW-1:0]   sp_reg;
    logic [7:0]               dt_reg;
    logic [7:0]               snd_reg;
    logic [63:0]              frame_reg [c8_pkg::SCREEN_H];
    logic                     wait_reg;
    logic [3:0]               wt_reg;
    logic [15:0]              lfsr_reg;

    // instruction working registers
    logic [7:0]  hi_reg;
    logic [15:0] opc_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [11:0] npc_reg;
    logic [1:0]  st_reg;
    logic [4:0]  cnt_reg;
    logic        hit_reg;
    logic [11:0] clr_reg;

    // result registers
    logic [7:0]  rd_out_reg;
    logic [63:0] row_out_reg;
    logic [11:0] pc_out_reg;
    logic        wait_out_reg;
    logic        snd_out_reg;
    logic [1:0]  st_out_reg;

    // memory port
    logic        m_we;
    logic [11:0] m_waddr;
    logic [7:0]  m_wdata;
    logic        m_re;
    logic [11:0] m_raddr;
    logic [7:0]  m_rdata;

    c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_SIZE)) u_mem (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    logic [3:0]  f_hi;
    logic [3:0]  f_x;
    logic [3:0]  f_y;
    logic [3:0]  f_n;
    logic [7:0]  f_kk;
    logic [11:0] f_nnn;
    logic [11:0] pc2;
    logic [11:0] pc4;
    logic [11:0] i_cnt;

    assign f_hi  = opc_reg[15:12];
    assign f_x   = opc_reg[11:8];
    assign f_y   = opc_reg[7:4];
    assign f_n   = opc_reg[3:0];
    assign f_kk  = opc_reg[7:0];
    assign f_nnn = opc_reg[11:0];
    assign pc2   = pc_reg + 12'd2;
    assign pc4   = pc_reg + 12'd4;
    assign i_cnt = i_reg + {7'd0, cnt_reg};

    // bcd digits of vx
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_r;
    logic [14:0] bcd_m;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    logic [7:0]  bcd_dig;

    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 2'd2;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 2'd1;
        end
        else
        begin
            bcd_h = 2'd0;
        end
        bcd_r = vx_reg - (8'(bcd_h) * 8'd100);
        bcd_m = {7'd0, bcd_r} * 15'd205;
        bcd_t = bcd_m[14:11];
        bcd_o = bcd_r - {bcd_t, 3'd0} - {3'd0, bcd_t, 1'b0};
        case (cnt_reg[1:0])
            2'd0:    bcd_dig = {6'd0, bcd_h};
            2'd1:    bcd_dig = {4'd0, bcd_t};
            default: bcd_dig = bcd_o;
        endcase
    end

    // register file read port
    logic [3:0] v_idx;
    logic [7:0] v_rd;

    always_comb
    begin
        unique case (cmd.op)
            c8_pkg::OP_READ_VX:  v_idx = f_x;
            c8_pkg::OP_READ_VY:  v_idx = (f_hi == c8_pkg::OPG_JPV) ? 4'd0 : f_y;
            default:             v_idx = cnt_reg[3:0];
        endcase
        v_rd = v_reg[v_idx];
    end

    // memory port selection
    always_comb
    begin
        m_we    = 1'b0;
        m_waddr = addr_b_reg;
        m_wdata = data_b_reg;
        m_re    = 1'b0;
        m_raddr = addr_b_reg;
        unique case (cmd.op)
            c8_pkg::OP_CLEAR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = (clr_reg < 12'(c8_pkg::FONT_BYTES)) ?
                          c8_pkg::font_byte(clr_reg[6:0]) : 8'd0;
            end
            c8_pkg::OP_MEMWR:    m_we = 1'b1;
            c8_pkg::OP_MEMRD:    m_re = 1'b1;
            c8_pkg::OP_FETCH0:
            begin
                m_re    = 1'b1;
                m_raddr = pc_reg;
            end
            c8_pkg::OP_FETCH1:
            begin
                m_re    = 1'b1;
                m_raddr = pc_reg + 12'd1;
            end
            c8_pkg::OP_DRAW_RD, c8_pkg::OP_LOAD_RD:
            begin
                m_re    = 1'b1;
                m_raddr = i_cnt;
            end
            c8_pkg::OP_BCD_WR:
            begin
                m_we    = 1'b1;
                m_waddr = i_cnt;
                m_wdata = bcd_dig;
            end
            c8_pkg::OP_STORE_WR:
            begin
                m_we    = 1'b1;
                m_waddr = i_cnt;
                m_wdata = v_rd;
            end
            default:
            begin
            end
        endcase
    end

    // combinational execute
    logic [11:0] ex_pc;
    logic [1:0]  ex_st;
    logic        ex_vx_we;
    logic [7:0]  ex_vx;
    logic        ex_vf_we;
    logic [7:0]  ex_vf;
    logic        ex_i_we;
    logic [11:0] ex_i;
    logic        ex_push;
    logic        ex_pop;
    logic        ex_cls;
    logic        ex_dt_we;
    logic        ex_snd_we;
    logic        ex_wait;
    logic        ex_lfsr_we;
    logic [8:0]  ex_sum;
    logic [15:0] lfsr_nx;
    logic        key_down;
    logic [c8_pkg::SPW-1:0] sp_m1;

    assign ex_sum   = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign lfsr_nx  = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? c8_pkg::LFSR_MASK : 16'd0);
    assign key_down = (vx_reg[7:4] == 4'd0) && keys_b_reg[vx_reg[3:0]];
    assign sp_m1    = sp_reg - 1'b1;

    always_comb
    begin
        ex_pc      = pc2;
        ex_st      = c8_pkg::ST_OK;
        ex_vx_we   = 1'b0;
        ex_vx      = vy_reg;
        ex_vf_we   = 1'b0;
        ex_vf      = 8'd0;
        ex_i_we    = 1'b0;
        ex_i       = f_nnn;
        ex_push    = 1'b0;
        ex_pop     = 1'b0;
        ex_cls     = 1'b0;
        ex_dt_we   = 1'b0;
        ex_snd_we  = 1'b0;
        ex_wait    = 1'b0;
        ex_lfsr_we = 1'b0;
        unique case (f_hi)
            c8_pkg::OPG_SYS:
            begin
                if (opc_reg == c8_pkg::OPC_CLS)
                begin
                    ex_cls = 1'b1;
                end
                else if (opc_reg == c8_pkg::OPC_RET)
                begin
                    if (sp_reg == '0)
                    begin
                        ex_st = c8_pkg::ST_UNDER;
                    end
                    else
                    begin
                        ex_pop = 1'b1;
                        ex_pc  = stk_reg[sp_m1[c8_pkg::SIW-1:0]];
                    end
                end
            end
            c8_pkg::OPG_JP:   ex_pc = f_nnn;
            c8_pkg::OPG_CALL:
            begin
                if (sp_reg >= c8_pkg::SPW'(c8_pkg::STACK_DEPTH))
                begin
                    ex_st = c8_pkg::ST_OVER;
                end
                else
                begin
                    ex_push = 1'b1;
                    ex_pc   = f_nnn;
                end
            end
            c8_pkg::OPG_SE:   ex_pc = (vx_reg == f_kk) ? pc4 : pc2;
            c8_pkg::OPG_SNE:  ex_pc = (vx_reg != f_kk) ? pc4 : pc2;
            c8_pkg::OPG_SEV:  ex_pc = (vx_reg == vy_reg) ? pc4 : pc2;
            c8_pkg::OPG_SNEV: ex_pc = (vx_reg != vy_reg) ? pc4 : pc2;
            c8_pkg::OPG_LD:
            begin
                ex_vx_we = 1'b1;
                ex_vx    = f_kk;
            end
            c8_pkg::OPG_ADD:
            begin
                ex_vx_we = 1'b1;
                ex_vx    = vx_reg + f_kk;
            end
            c8_pkg::OPG_ALU:
            begin
                ex_vx_we = 1'b1;
                case (f_n)
                    c8_pkg::ALU_MOV: ex_vx = vy_reg;
                    c8_pkg::ALU_OR:  ex_vx = vx_reg | vy_reg;
                    c8_pkg::ALU_AND: ex_vx = vx_reg & vy_reg;
                    c8_pkg::ALU_XOR: ex_vx = vx_reg ^ vy_reg;
                    c8_pkg::ALU_ADD:
                    begin
                        ex_vx    = ex_sum[7:0];
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'd0, ex_sum[8]};
                    end
                    c8_pkg::ALU_SUB:
                    begin
                        ex_vx    = vx_reg - vy_reg;
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'd0, vx_reg >= vy_reg};
                    end
                    c8_pkg::ALU_SHR:
                    begin
                        ex_vx    = {1'b0, vx_reg[7:1]};
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'd0, vx_reg[0]};
                    end
                    c8_pkg::ALU_SBN:
                    begin
                        ex_vx    = vy_reg - vx_reg;
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'd0, vy_reg >= vx_reg};
                    end
                    c8_pkg::ALU_SHL:
                    begin
                        ex_vx    = {vx_reg[6:0], 1'b0};
                        ex_vf_we = 1'b1;
                        ex_vf    = {7'd0, vx_reg[7]};
                    end
                    default:
                    begin
                        ex_vx_we = 1'b0;
                        ex_st    = c8_pkg::ST_UNKNOWN;
                    end
                endcase
            end
            c8_pkg::OPG_LDI:
            begin
                ex_i_we = 1'b1;
            end
            c8_pkg::OPG_JPV:  ex_pc = f_nnn + {4'd0, vy_reg};
            c8_pkg::OPG_RND:
            begin
                ex_vx_we   = 1'b1;
                ex_vx      = lfsr_nx[7:0] & f_kk;
                ex_lfsr_we = 1'b1;
            end
            c8_pkg::OPG_DRW:
            begin
            end
            c8_pkg::OPG_SKP:
            begin
                if (f_kk == c8_pkg::LO_SKP)
                begin
                    ex_pc = key_down ? pc4 : pc2;
                end
                else if (f_kk == c8_pkg::LO_SKNP)
                begin
                    ex_pc = key_down ? pc2 : pc4;
                end
                else
                begin
                    ex_st = c8_pkg::ST_UNKNOWN;
                end
            end
            default:
            begin
                case (f_kk)
                    c8_pkg::LO_GDT:
                    begin
                        ex_vx_we = 1'b1;
                        ex_vx    = dt_reg;
                    end
                    c8_pkg::LO_WKEY: ex_wait   = 1'b1;
                    c8_pkg::LO_SDT:  ex_dt_we  = 1'b1;
                    c8_pkg::LO_SST:  ex_snd_we = 1'b1;
                    c8_pkg::LO_ADDI:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = i_reg + {4'd0, vx_reg};
                    end
                    c8_pkg::LO_FONT:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = {6'd0, vx_reg[3:0], 2'd0} + {8'd0, vx_reg[3:0]};
                    end
                    c8_pkg::LO_BCD, c8_pkg::LO_STO, c8_pkg::LO_LDM:
                    begin
                    end
                    default: ex_st = c8_pkg::ST_UNKNOWN;
                endcase
            end
        endcase
    end

    // sprite row placement with wrap
    logic [c8_pkg::RW-1:0] draw_y;
    logic [63:0]           spr_base;
    logic [63:0]           spr_mask;
    logic [6:0]            spr_sh;

    assign draw_y   = vy_reg[c8_pkg::RW-1:0] + cnt_reg[c8_pkg::RW-1:0];
    assign spr_base = {m_rdata, 56'd0};
    assign spr_sh   = {1'b0, vx_reg[c8_pkg::XW-1:0]};
    assign spr_mask = (spr_base >> spr_sh) | (spr_base << (7'd64 - spr_sh));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= 8'd0;
            end
            for (int k = 0; k < c8_pkg::SCREEN_H; k++)
            begin
                frame_reg[k] <= 64'd0;
            end
            i_reg    <= 12'd0;
            pc_reg   <= 12'(c8_pkg::PROGRAM_START);
            sp_reg   <= '0;
            dt_reg   <= 8'd0;
            snd_reg  <= 8'd0;
            wait_reg <= 1'b0;
            wt_reg   <= 4'd0;
            lfsr_reg <= c8_pkg::LFSR_SEED;
            clr_reg  <= 12'd0;
            cnt_reg  <= 5'd0;
            st_reg   <= c8_pkg::ST_OK;
            cmd_b_reg <= c8_pkg::CMD_WRITE;
        end
        else
        begin
            if (cmd.take)
            begin
                cmd_b_reg <= command;
                st_reg    <= c8_pkg::ST_OK;
            end
            unique case (cmd.op)
                c8_pkg::OP_CLEAR:    clr_reg <= clr_reg + 12'd1;
                c8_pkg::OP_KEY:
                begin
                    if (wait_reg)
                    begin
                        v_reg[wt_reg] <= {4'd0, keyv_b_reg};
                        wait_reg      <= 1'b0;
                    end
                end
                c8_pkg::OP_EXEC:
                begin
                    cnt_reg <= 5'd0;
                    st_reg  <= ex_st;
                    // the flag takes vf when x is f
                    if (ex_vx_we && !(ex_vf_we && f_x == 4'hF))
                    begin
                        v_reg[f_x] <= ex_vx;
                    end
                    if (ex_vf_we)
                    begin
                        v_reg[15] <= ex_vf;
                    end
                    if (ex_i_we)
                    begin
                        i_reg <= ex_i;
                    end
                    if (ex_push)
                    begin
                        stk_reg[sp_reg[c8_pkg::SIW-1:0]] <= pc2;
                        sp_reg <= sp_reg + 1'b1;
                    end
                    if (ex_pop)
                    begin
                        sp_reg <= sp_m1;
                    end
                    if (ex_cls)
                    begin
                        for (int k = 0; k < c8_pkg::SCREEN_H; k++)
                        begin
                            frame_reg[k] <= 64'd0;
                        end
                    end
                    if (ex_dt_we)
                    begin
                        dt_reg <= vx_reg;
                    end
                    if (ex_snd_we)
                    begin
                        snd_reg <= vx_reg;
                    end
                    if (ex_wait)
                    begin
                        wait_reg <= 1'b1;
                        wt_reg   <= f_x;
                    end
                    if (ex_lfsr_we)
                    begin
                        lfsr_reg <= lfsr_nx;
                    end
                end
                c8_pkg::OP_DRAW_WR:
                begin
                    frame_reg[draw_y] <= frame_reg[draw_y] ^ spr_mask;
                    cnt_reg           <= cnt_reg + 5'd1;
                end
                c8_pkg::OP_DRAW_FLAG: v_reg[15] <= {7'd0, hit_reg};
                c8_pkg::OP_BCD_WR, c8_pkg::OP_STORE_WR:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
                c8_pkg::OP_LOAD_WR:
                begin
                    v_reg[cnt_reg[3:0]] <= m_rdata;
                    cnt_reg             <= cnt_reg + 5'd1;
                end
                c8_pkg::OP_RETIRE:
                begin
                    pc_reg <= npc_reg;
                    if (dt_reg != 8'd0)
                    begin
                        dt_reg <= dt_reg - 8'd1;
                    end
                    if (snd_reg != 8'd0)
                    begin
                        snd_reg <= snd_reg - 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            addr_b_reg <= address;
            data_b_reg <= data;
            keys_b_reg <= keys_down;
            keyv_b_reg <= key_value;
            row_b_reg  <= row;
        end
        unique case (cmd.op)
            c8_pkg::OP_FETCH1:  hi_reg  <= m_rdata;
            c8_pkg::OP_FETCH2:  opc_reg <= {hi_reg, m_rdata};
            c8_pkg::OP_READ_VX: vx_reg  <= v_rd;
            c8_pkg::OP_READ_VY: vy_reg  <= v_rd;
            c8_pkg::OP_EXEC:
            begin
                npc_reg <= ex_pc;
                hit_reg <= 1'b0;
            end
            c8_pkg::OP_DRAW_WR:
            begin
                hit_reg <= hit_reg | (|(frame_reg[draw_y] & spr_mask));
            end
            c8_pkg::OP_RESULT:
            begin
                rd_out_reg   <= (cmd_b_reg == c8_pkg::CMD_READ) ? m_rdata : 8'd0;
                row_out_reg  <= (cmd_b_reg == c8_pkg::CMD_ROW) ?
                                frame_reg[row_b_reg[c8_pkg::RW-1:0]] : 64'd0;
                pc_out_reg   <= pc_reg;
                wait_out_reg <= wait_reg;
                snd_out_reg  <= (snd_reg != 8'd0);
                st_out_reg   <= st_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign read_data   = rd_out_reg;
    assign display_row = row_out_reg;
    assign pc          = pc_out_reg;
    assign waiting     = wait_out_reg;
    assign sound_on    = snd_out_reg;
    assign status      = st_out_reg;

    assign stat.cmd        = cmd_b_reg;
    assign stat.waiting    = wait_reg;
    assign stat.opc        = opc_reg;
    assign stat.cnt        = cnt_reg;
    assign stat.clear_last = (clr_reg == 12'(c8_pkg::MEM_SIZE - 1));

    `C8_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= c8_pkg::SPW'(c8_pkg::STACK_DEPTH))
    `C8_ASSERT_NEXT(a_wait_from_exec, !wait_reg && cmd.op != c8_pkg::OP_EXEC, !wait_reg)

endmodule

### hdl/c8_control.sv
`include "chip8_instruction_core_defines.svh"

module c8_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output c8_pkg::dp_cmd_t    cmd,
    input  c8_pkg::dp_stat_t   stat
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_F1,
        S_F2,
        S_VX,
        S_VY,
        S_EXEC,
        S_DRD,
        S_DWR,
        S_DFLAG,
        S_BCD,
        S_STO,
        S_LRD,
        S_LWR,
        S_RETIRE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   take;
    logic   slot_free;

    logic [3:0] o_hi;
    logic [3:0] o_x;
    logic [3:0] o_n;
    logic [7:0] o_kk;
    logic       is_draw;
    logic       is_bcd;
    logic       is_sto;
    logic       is_ldm;

    assign o_hi = stat.opc[15:12];
    assign o_x  = stat.opc[11:8];
    assign o_n  = stat.opc[3:0];
    assign o_kk = stat.opc[7:0];
    assign is_draw = (o_hi == c8_pkg::OPG_DRW);
    assign is_bcd  = (o_hi == c8_pkg::OPG_MISC) && (o_kk == c8_pkg::LO_BCD);
    assign is_sto  = (o_hi == c8_pkg::OPG_MISC) && (o_kk == c8_pkg::LO_STO);
    assign is_ldm  = (o_hi == c8_pkg::OPG_MISC) && (o_kk == c8_pkg::LO_LDM);

    assign in_ready  = (state_reg == S_IDLE);
    assign take      = in_ready && in_valid;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take   = take;
        cmd.op     = c8_pkg::OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = c8_pkg::OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (stat.cmd)
                    c8_pkg::CMD_WRITE: cmd.op = c8_pkg::OP_MEMWR;
                    c8_pkg::CMD_READ:  cmd.op = c8_pkg::OP_MEMRD;
                    c8_pkg::CMD_KEY:   cmd.op = c8_pkg::OP_KEY;
                    c8_pkg::CMD_STEP:
                    begin
                        if (!stat.waiting)
                        begin
                            cmd.op     = c8_pkg::OP_FETCH0;
                            state_next = S_F1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_F1:
            begin
                cmd.op     = c8_pkg::OP_FETCH1;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.op     = c8_pkg::OP_FETCH2;
                state_next = S_VX;
            end
            S_VX:
            begin
                cmd.op     = c8_pkg::OP_READ_VX;
                state_next = S_VY;
            end
            S_VY:
            begin
                cmd.op     = c8_pkg::OP_READ_VY;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.op = c8_pkg::OP_EXEC;
                if (is_draw)
                begin
                    state_next = (o_n == 4'd0) ? S_DFLAG : S_DRD;
                end
                else if (is_bcd)
                begin
                    state_next = S_BCD;
                end
                else if (is_sto)
                begin
                    state_next = S_STO;
                end
                else if (is_ldm)
                begin
                    state_next = S_LRD;
                end
                else
                begin
                    state_next = S_RETIRE;
                end
            end
            S_DRD:
            begin
                cmd.op     = c8_pkg::OP_DRAW_RD;
                state_next = S_DWR;
            end
            S_DWR:
            begin
                cmd.op     = c8_pkg::OP_DRAW_WR;
                state_next = (stat.cnt + 5'd1 == {1'b0, o_n}) ? S_DFLAG : S_DRD;
            end
            S_DFLAG:
            begin
                cmd.op     = c8_pkg::OP_DRAW_FLAG;
                state_next = S_RETIRE;
            end
            S_BCD:
            begin
                cmd.op = c8_pkg::OP_BCD_WR;
                if (stat.cnt == 5'd2)
                begin
                    state_next = S_RETIRE;
                end
            end
            S_STO:
            begin
                cmd.op = c8_pkg::OP_STORE_WR;
                if (stat.cnt == {1'b0, o_x})
                begin
                    state_next = S_RETIRE;
                end
            end
            S_LRD:
            begin
                cmd.op     = c8_pkg::OP_LOAD_RD;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                cmd.op     = c8_pkg::OP_LOAD_WR;
                state_next = (stat.cnt == {1'b0, o_x}) ? S_RETIRE : S_LRD;
            end
            S_RETIRE:
            begin
                cmd.op     = c8_pkg::OP_RETIRE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.op     = c8_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `C8_ASSERT_NOW(a_no_take_in_clear, state_reg == S_CLEAR, !in_ready)
    `C8_ASSERT_NEXT(a_take_leaves_idle, take, state_reg != S_IDLE)
    `C8_ASSERT_NEXT(a_result_posts, state_reg == S_DONE && slot_free, out_valid_reg)

endmodule

### hdl/chip8_instruction_core.sv
// chip-8 instruction core: one request beat in, one response beat out. after reset the
// core loads the font and zeroes its 4 kB memory, one byte a cycle, and takes no
// request in that time. memory write, memory read, key press and display row beats go
// through accept, dispatch and post the response; an execute step goes through accept,
// first fetch read, second fetch read, opcode latch, two register reads, execute,
// retire and post, plus a read and a write per sprite row and the collision flag for
// Dxyn, a write per digit for Fx33, a write per register for Fx55 and a read and a
// write per register for Fx65, as the memory has a single read and a single write port.
// a finished response sits in an output register, and the next request beat is taken
// while it waits; a response still held when the next one is ready stalls the core
module chip8_instruction_core (
    input  logic      clk,
    input  logic      rst_n,
    c8_req_if.sink    request,
    c8_rsp_if.source  response
);

    c8_pkg::dp_cmd_t  cmd;
    c8_pkg::dp_stat_t stat;

    // sequencer: handshakes and instruction phases
    c8_control u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // machine state, memory, frame buffer and response register
    c8_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (request.command),
        .address     (request.address),
        .data        (request.data),
        .keys_down   (request.keys_down),
        .key_value   (request.key_value),
        .row         (request.row),
        .read_data   (response.read_data),
        .display_row (response.display_row),
        .pc          (response.pc),
        .waiting     (response.waiting),
        .sound_on    (response.sound_on),
        .status      (response.status)
    );

endmodule

### verif/tb_chip8_instruction_core.sv
`default_nettype none

module tb_chip8_instruction_core;
    timeunit 1ns;
    timeprecision 1ps;

    import c8_pkg::*;

    // one response beat as the core should present it
    typedef struct {
        logic [7:0]  read_data;
        logic [63:0] display_row;
        logic [11:0] pc;
        logic        waiting;
        logic        sound_on;
        logic [1:0]  status;
    } c8_rsp_t;

    // shadow copy of the core: memory, registers, stack, timers and frame
    class c8_scoreboard;
        bit [7:0]  mem [MEM_SIZE];
        bit [7:0]  vreg [16];
        bit [11:0] ireg;
        bit [11:0] pc;
        bit [11:0] stack [STACK_DEPTH];
        int        depth;
        bit [7:0]  delay_t;
        bit [7:0]  sound_t;
        bit [63:0] frame [SCREEN_H];
        bit        halted;
        bit [3:0]  halt_reg;
        bit [15:0] lfsr;
        c8_rsp_t   pending [$];
        int        errors;
        int        checked;
        int        steps;
        int        status_seen [4];

        function void clear_state();
            byte unsigned glyphs [80] = '{
                8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
                8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
                8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
                8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
                8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
                8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
                8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
                8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80};
            foreach (mem[i]) mem[i] = (i < 80) ? glyphs[i] : 8'h00;
            foreach (vreg[i]) vreg[i] = '0;
            foreach (frame[i]) frame[i] = '0;
            ireg = '0;
            pc = 12'(PROGRAM_START);
            depth = 0;
            delay_t = '0;
            sound_t = '0;
            halted = 1'b0;
            halt_reg = '0;
            lfsr = LFSR_SEED;
        endfunction

        function void draw(bit [3:0] x, bit [3:0] y, bit [3:0] n);
            bit [5:0]  x0;
            bit [5:0]  xx;
            bit [4:0]  yy;
            bit [7:0]  bits;
            bit [11:0] a;
            bit [63:0] m;
            bit        hit;
            x0 = vreg[x][5:0];
            hit = 1'b0;
            for (int r = 0; r < n; r++) begin
                a = ireg + 12'(r);
                bits = mem[a];
                yy = vreg[y][4:0] + 5'(r);
                for (int c = 0; c < 8; c++) begin
                    if (bits[7-c]) begin
                        xx = x0 + 6'(c);
                        m = 64'd1 << (63 - xx);
                        if ((frame[yy] & m) != 0) hit = 1'b1;
                        frame[yy] ^= m;
                    end
                end
            end
            vreg[15] = {7'd0, hit};
        endfunction

        // one instruction at the program counter, then the timers count down
        function bit [1:0] run_instruction(bit [15:0] keys);
            bit [7:0]  hi;
            bit [7:0]  lo;
            bit [15:0] op;
            bit [3:0]  x;
            bit [3:0]  y;
            bit [11:0] nnn;
            bit [11:0] nxt;
            bit [11:0] a;
            bit [8:0]  sum;
            bit        flag;
            bit        down;
            bit        lsb;
            bit [1:0]  st;
            hi = mem[pc];
            a = pc + 12'd1;
            lo = mem[a];
            op = {hi, lo};
            x = hi[3:0];
            y = lo[7:4];
            nnn = op[11:0];
            nxt = pc + 12'd2;
            st = ST_OK;
            case (hi[7:4])
                OPG_SYS: begin
                    if (op == OPC_CLS) foreach (frame[i]) frame[i] = '0;
                    else if (op == OPC_RET) begin
                        if (depth == 0) st = ST_UNDER;
                        else begin
                            depth--;
                            nxt = stack[depth];
                        end
                    end
                end
                OPG_JP: nxt = nnn;
                OPG_CALL: begin
                    if (depth >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        stack[depth] = nxt;
                        depth++;
                        nxt = nnn;
                    end
                end
                OPG_SE:   if (vreg[x] == lo) nxt += 12'd2;
                OPG_SNE:  if (vreg[x] != lo) nxt += 12'd2;
                OPG_SEV:  if (vreg[x] == vreg[y]) nxt += 12'd2;
                OPG_LD:   vreg[x] = lo;
                OPG_ADD:  vreg[x] = vreg[x] + lo;
                OPG_ALU: begin
                    case (lo[3:0])
                        ALU_MOV: vreg[x] = vreg[y];
                        ALU_OR:  vreg[x] |= vreg[y];
                        ALU_AND: vreg[x] &= vreg[y];
                        ALU_XOR: vreg[x] ^= vreg[y];
                        ALU_ADD: begin
                            sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                            vreg[x] = sum[7:0];
                            vreg[15] = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                            flag = vreg[x] >= vreg[y];
                            vreg[x] = vreg[x] - vreg[y];
                            vreg[15] = {7'd0, flag};
                        end
                        ALU_SHR: begin
                            flag = vreg[x][0];
                            vreg[x] = vreg[x] >> 1;
                            vreg[15] = {7'd0, flag};
                        end
                        ALU_SBN: begin
                            flag = vreg[y] >= vreg[x];
                            vreg[x] = vreg[y] - vreg[x];
                            vreg[15] = {7'd0, flag};
                        end
                        ALU_SHL: begin
                            flag = vreg[x][7];
                            vreg[x] = vreg[x] << 1;
                            vreg[15] = {7'd0, flag};
                        end
                        default: st = ST_UNKNOWN;
                    endcase
                end
                OPG_SNEV: if (vreg[x] != vreg[y]) nxt += 12'd2;
                OPG_LDI:  ireg = nnn;
                OPG_JPV:  nxt = nnn + {4'd0, vreg[0]};
                OPG_RND: begin
                    lsb = lfsr[0];
                    lfsr = lfsr >> 1;
                    if (lsb) lfsr ^= LFSR_MASK;
                    vreg[x] = lfsr[7:0] & lo;
                end
                OPG_DRW: draw(x, y, lo[3:0]);
                OPG_SKP: begin
                    // a register value above 15 never names a held key
                    down = (vreg[x] < 8'd16) && keys[vreg[x][3:0]];
                    if (lo == LO_SKP) begin
                        if (down) nxt += 12'd2;
                    end
                    else if (lo == LO_SKNP) begin
                        if (!down) nxt += 12'd2;
                    end
                    else st = ST_UNKNOWN;
                end
                default: begin
                    case (lo)
                        LO_GDT:  vreg[x] = delay_t;
                        LO_WKEY: begin
                            halted = 1'b1;
                            halt_reg = x;
                        end
                        LO_SDT:  delay_t = vreg[x];
                        LO_SST:  sound_t = vreg[x];
                        LO_ADDI: ireg = ireg + {4'd0, vreg[x]};
                        LO_FONT: ireg = 12'(vreg[x][3:0]) * 12'd5;
                        LO_BCD: begin
                            mem[ireg] = vreg[x] / 8'd100;
                            a = ireg + 12'd1;
                            mem[a] = (vreg[x] / 8'd10) % 8'd10;
                            a = ireg + 12'd2;
                            mem[a] = vreg[x] % 8'd10;
                        end
                        LO_STO: for (int i = 0; i <= x; i++) begin
                            a = ireg + 12'(i);
                            mem[a] = vreg[i];
                        end
                        LO_LDM: for (int i = 0; i <= x; i++) begin
                            a = ireg + 12'(i);
                            vreg[i] = mem[a];
                        end
                        default: st = ST_UNKNOWN;
                    endcase
                end
            endcase
            pc = nxt;
            if (delay_t != 0) delay_t--;
            if (sound_t != 0) sound_t--;
            return st;
        endfunction

        // an accepted request beat: update the shadow and queue its response
        function void note_request(bit [2:0] cmd, bit [11:0] addr, bit [7:0] data,
                                   bit [15:0] keys, bit [3:0] key, bit [4:0] row);
            c8_rsp_t r;
            r.read_data = '0;
            r.display_row = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_WRITE: mem[addr] = data;
                CMD_STEP: if (!halted) begin
                    r.status = run_instruction(keys);
                    steps++;
                    status_seen[r.status]++;
                end
                CMD_KEY: if (halted) begin
                    vreg[halt_reg] = {4'd0, key};
                    halted = 1'b0;
                end
                CMD_ROW:  r.display_row = frame[row];
                CMD_READ: r.read_data = mem[addr];
                default: ;
            endcase
            r.pc = pc;
            r.waiting = halted;
            r.sound_on = sound_t != 0;
            pending.push_back(r);
        endfunction

        function void check_response(c8_rsp_t got);
            c8_rsp_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("response beat with nothing outstanding, pc %h", got.pc);
                return;
            end
            want = pending.pop_front();
            if (got.read_data !== want.read_data || got.display_row !== want.display_row ||
                got.pc !== want.pc || got.waiting !== want.waiting ||
                got.sound_on !== want.sound_on || got.status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch at beat %0d: want rd %h row %h pc %h w %b s %b st %0d,",
                              " got rd %h row %h pc %h w %b s %b st %0d"},
                             checked, want.read_data, want.display_row, want.pc, want.waiting,
                             want.sound_on, want.status, got.read_data, got.display_row,
                             got.pc, got.waiting, got.sound_on, got.status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    c8_req_if request ();
    c8_rsp_if response ();

    chip8_instruction_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request.sink),
        .response (response.source)
    );

    c8_scoreboard board = new();
    bit quiet;   // when set, neither side idles

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request beat; valid stays high straight into the next beat when no gap follows
    task automatic send_beat(bit [2:0] cmd, bit [11:0] addr, bit [7:0] data,
                             bit [15:0] keys, bit [3:0] key, bit [4:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid     <= 1'b1;
        request.command   <= cmd;
        request.address   <= addr;
        request.data      <= data;
        request.keys_down <= keys;
        request.key_value <= key;
        request.row       <= row;
        @(posedge clk);
        while (!request.ready) @(posedge clk);
        board.note_request(cmd, addr, data, keys, key, row);
    endtask

    // place an instruction at the predicted pc and execute it
    task automatic run_op(bit [15:0] op, bit [15:0] keys = 16'h0000);
        send_beat(CMD_WRITE, board.pc, op[15:8], '0, '0, '0);
        send_beat(CMD_WRITE, board.pc + 12'd1, op[7:0], '0, '0, '0);
        send_beat(CMD_STEP, $urandom, $urandom, keys, $urandom, $urandom);
    endtask

    // random instruction spread over every opcode group, faults included
    function automatic bit [15:0] random_op();
        bit [3:0]  grp;
        bit [3:0]  x;
        bit [3:0]  y;
        bit [7:0]  lo;
        bit [7:0]  misc [11];
        misc = '{LO_GDT, LO_WKEY, LO_SDT, LO_SST, LO_ADDI, LO_FONT, LO_BCD, LO_STO,
                 LO_LDM, 8'h00, 8'hFF};
        grp = $urandom;
        x = $urandom;
        y = $urandom;
        lo = $urandom;
        case (grp)
            OPG_SYS: case ($urandom_range(0, 2))
                0: return OPC_CLS;
                1: return OPC_RET;
                default: return {4'h0, x, lo};
            endcase
            OPG_SKP: case ($urandom_range(0, 4))
                0, 1: return {grp, x, LO_SKP};
                2, 3: return {grp, x, LO_SKNP};
                default: return {grp, x, lo};
            endcase
            OPG_MISC: begin
                lo = misc[$urandom_range(0, 10)];
                if (lo == 8'hFF) lo = $urandom;
                // keep waits for a key from swamping the run
                if (lo == LO_WKEY && $urandom_range(0, 2) != 0) lo = LO_ADDI;
                return {grp, x, lo};
            end
            default: return {grp, x, y, lo[3:0]};
        endcase
    endfunction

    // response side: ready comes in bursts broken by stalls
    initial
    begin
        int gap;
        forever
        begin
            response.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                response.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        c8_rsp_t got;
        if (rst_n && response.valid && response.ready)
        begin
            got.read_data   = response.read_data;
            got.display_row = response.display_row;
            got.pc          = response.pc;
            got.waiting     = response.waiting;
            got.sound_on    = response.sound_on;
            got.status      = response.status;
            board.check_response(got);
        end
    end

    initial
    begin
        #30ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        request.valid     <= 1'b0;
        request.command   <= CMD_WRITE;
        request.address   <= '0;
        request.data      <= '0;
        request.keys_down <= '0;
        request.key_value <= '0;
        request.row       <= '0;
        board.clear_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: font and top of memory, register extremes and flag corner cases
        send_beat(CMD_READ, 12'd0, 8'h00, 16'h0000, 4'h0, 5'd0);
        send_beat(CMD_READ, 12'hFFF, 8'hFF, 16'hFFFF, 4'hF, 5'd31);
        run_op(16'h6FFF);                 // vf = 255
        run_op(16'h60FF);
        run_op(16'h8F04);                 // carry lands in vf, flag wins
        run_op(16'h8F0E);                 // shift left takes bit 7
        run_op(16'h613F);                 // sprite at the far corner wraps both ways
        run_op(16'h621F);
        run_op(16'hA000);
        run_op(16'hD12F);
        run_op(16'hD125);                 // redraw erases, collision flag
        send_beat(CMD_ROW, 12'd0, 8'd0, 16'd0, 4'd0, 5'd31);
        run_op(16'h6510);                 // key test with vx above 15
        run_op(16'hE59E, 16'hFFFF);
        run_op(16'hC3FF);
        run_op(16'h0123);                 // system call ignored
        run_op(16'h8128);                 // unknown alu code
        run_op(16'h6AC8);
        run_op(16'hF518);
        run_op(16'hFA0A);                 // wait, step while waiting, then the key
        send_beat(CMD_STEP, 12'd0, 8'd0, 16'hFFFF, 4'h0, 5'd0);
        send_beat(CMD_KEY, 12'd0, 8'd0, 16'd0, 4'hF, 5'd0);
        send_beat(CMD_KEY, 12'd0, 8'd0, 16'd0, 4'h3, 5'd0);
        send_beat(3'd7, 12'hFFF, 8'hFF, 16'hFFFF, 4'hF, 5'd31);
        run_op(16'h00E0);

        // call to itself until the stack overflows, then return until it underflows
        run_op(16'h1300);
        send_beat(CMD_WRITE, 12'h300, 8'h23, '0, '0, '0);
        send_beat(CMD_WRITE, 12'h301, 8'h00, '0, '0, '0);
        repeat (STACK_DEPTH + 1) send_beat(CMD_STEP, '0, '0, '0, '0, '0);
        send_beat(CMD_WRITE, 12'h302, 8'h00, '0, '0, '0);
        send_beat(CMD_WRITE, 12'h303, 8'hEE, '0, '0, '0);
        repeat (STACK_DEPTH + 1) send_beat(CMD_STEP, '0, '0, '0, '0, '0);

        // random part: mostly freshly written instructions, plus reads, keys and noise
        for (int i = 0; i < 450; i++)
        begin
            int pick;
            if (i % 75 == 0) quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (board.halted && pick < 30)
                send_beat(CMD_KEY, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 70)
                run_op(random_op(), $urandom);
            else if (pick < 78)
                send_beat(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 83)
                send_beat(CMD_KEY, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 89)
                send_beat(CMD_ROW, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 95)
                send_beat(CMD_READ, ($urandom_range(0, 1) != 0) ? board.ireg : 12'($urandom),
                          $urandom, $urandom, $urandom, $urandom);
            else if (pick < 98)
                send_beat(CMD_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_beat(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        end
        request.valid <= 1'b0;

        // drain, then a short settle for any stray beat
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        $display("executed %0d instructions: %0d unknown, %0d overflow, %0d underflow",
                 board.steps, board.status_seen[ST_UNKNOWN], board.status_seen[ST_OVER],
                 board.status_seen[ST_UNDER]);
        $display("checked %0d response beats, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/c8_pkg.sv
hdl/c8_req_if.sv
hdl/c8_rsp_if.sv
hdl/c8_ram.sv
hdl/c8_datapath.sv
hdl/c8_control.sv
hdl/chip8_instruction_core.sv
verif/tb_chip8_instruction_core.sv
